// File: rtl/assert_macros.svh
// Assertion macros for the checker file of the marquee scroller.
// Each macro samples on i_clk and is switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define GMS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent in the cycle after the antecedent.
`define GMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gms_pkg.sv
// Shared types and constants of the glyph marquee scroller.
// Used by the front end, the job queue, the back end and the top level.
package gms_pkg;

    localparam int MAX_GLYPHS  = 16;
    localparam int GLYPH_SLOTS = 16;
    localparam int GLYPH_SIZE  = 16;
    localparam int GLYPH_LOG   = $clog2(GLYPH_SIZE);
    localparam int SLOT_W      = $clog2(GLYPH_SLOTS);
    localparam int ROW_W       = $clog2(GLYPH_SIZE);
    localparam int CNT_W       = $clog2(MAX_GLYPHS + 1);
    localparam int GCNT_W      = 8;
    localparam int PIX_W       = 16;
    localparam int TICK_W      = 16;
    // Wide enough for +16 and for one below minus the whole strip width.
    localparam int OFS_W       = $clog2(MAX_GLYPHS * GLYPH_SIZE + GLYPH_SIZE + 1) + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [TICK_W-1:0]         PERIOD_RESET = TICK_W'(40);
    localparam logic signed [OFS_W-1:0]   OFS_START    = OFS_W'(GLYPH_SIZE);

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_TICK  = 2'd2
    } t_cmd;

    // One unit of work for the back end: a glyph row write or a frame step.
    typedef struct packed {
        logic                    is_load;
        logic [SLOT_W-1:0]       slot;
        logic [ROW_W-1:0]        row;
        logic [PIX_W-1:0]        bits;
        logic signed [OFS_W-1:0] ofs;
        logic [CNT_W-1:0]        count;
        logic                    fin;
        logic                    scroll;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// File: rtl/gms_queue.sv
// Short job queue between the front end and the back end.
// Depends on gms_pkg for the job type and the queue depth.
module gms_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gms_pkg::t_job i_job,
    input  logic          i_pop,
    output gms_pkg::t_job o_head,
    output gms_pkg::t_qstat o_stat
);
    import gms_pkg::*;

    t_job              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QPTR_W:0]   r_fill, n_fill;
    logic              w_push;
    logic              w_pop;

    assign o_stat.full  = (r_fill == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_stat.empty = (r_fill == '0);
    assign o_head       = r_slots[r_rd_ptr];

    assign w_push = i_push && !o_stat.full;
    assign w_pop  = i_pop && !o_stat.empty;

    always_comb begin
        n_wr_ptr = w_push ? QPTR_W'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = w_pop  ? QPTR_W'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_fill   = r_fill;
        if (w_push && !w_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (w_pop && !w_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slots[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/gms_front.sv
// Front end of the marquee scroller: decodes each beat, keeps the scroll
// state and the tick counter, and queues load and frame-step jobs.
// Depends on gms_pkg.
module gms_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_cmd,
    input  logic [gms_pkg::SLOT_W-1:0]  i_glyph_index,
    input  logic [gms_pkg::ROW_W-1:0]   i_row_index,
    input  logic [gms_pkg::PIX_W-1:0]   i_row_bits,
    input  logic [gms_pkg::GCNT_W-1:0]  i_glyph_count,
    input  logic                        i_cfg_we,
    input  logic [gms_pkg::TICK_W-1:0]  i_cfg_wdata,
    output logic                        o_push,
    output gms_pkg::t_job               o_job
);
    import gms_pkg::*;

    logic [TICK_W-1:0]       r_period, n_period;
    logic [TICK_W-1:0]       r_tick, n_tick;
    logic signed [OFS_W-1:0] r_ofs, n_ofs;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_active, n_active;
    logic [TICK_W-1:0]       w_tick_inc;
    logic signed [OFS_W-1:0] w_ofs_dec;
    logic [OFS_W-1:0]        w_total;
    logic [OFS_W:0]          w_end_sum;
    logic                    w_fin;

    assign w_tick_inc = r_tick + 1'b1;
    assign w_ofs_dec  = r_ofs - 1'b1;
    assign w_total    = OFS_W'(r_count) << GLYPH_LOG;
    // The scroll ends once the new offset plus the strip width goes negative.
    assign w_end_sum  = {w_ofs_dec[OFS_W-1], w_ofs_dec} + {1'b0, w_total};
    assign w_fin      = w_end_sum[OFS_W];

    always_comb begin
        n_period = i_cfg_we ? i_cfg_wdata : r_period;
        n_tick   = r_tick;
        n_ofs    = r_ofs;
        n_count  = r_count;
        n_active = r_active;
        o_push   = 1'b0;
        o_job    = '0;
        if (i_accept) begin
            case (i_cmd)
                CMD_LOAD: begin
                    o_push       = 1'b1;
                    o_job.is_load = 1'b1;
                    o_job.slot   = i_glyph_index;
                    o_job.row    = i_row_index;
                    o_job.bits   = i_row_bits;
                end
                CMD_START: begin
                    n_count  = (i_glyph_count > GCNT_W'(MAX_GLYPHS)) ?
                               CNT_W'(MAX_GLYPHS) : CNT_W'(i_glyph_count);
                    n_ofs    = OFS_START;
                    n_tick   = '0;
                    n_active = 1'b1;
                end
                CMD_TICK: begin
                    if (r_active) begin
                        if (w_tick_inc < r_period) begin
                            n_tick = w_tick_inc;
                        end else begin
                            n_tick       = '0;
                            n_ofs        = w_ofs_dec;
                            n_active     = !w_fin;
                            o_push       = 1'b1;
                            o_job.ofs    = r_ofs;
                            o_job.count  = r_count;
                            o_job.fin    = w_fin;
                            o_job.scroll = !w_fin;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_tick   <= '0;
            r_ofs    <= OFS_START;
            r_count  <= '0;
            r_active <= 1'b0;
        end else begin
            r_period <= n_period;
            r_tick   <= n_tick;
            r_ofs    <= n_ofs;
            r_count  <= n_count;
            r_active <= n_active;
        end
    end

endmodule

// File: rtl/gms_back.sv
// Back end of the marquee scroller: holds the glyph store, performs row
// writes and renders frame steps one display row per cycle.
// Depends on gms_pkg.
module gms_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  gms_pkg::t_job              i_head,
    input  gms_pkg::t_qstat            i_qstat,
    output logic                       o_pop,
    output logic                       o_strobe,
    output logic [gms_pkg::ROW_W-1:0]  o_frame_row,
    output logic [gms_pkg::PIX_W-1:0]  o_frame_bits,
    output logic                       o_last,
    output logic                       o_scrolling
);
    import gms_pkg::*;

    localparam int ADDR_W = SLOT_W + ROW_W;

    typedef enum logic {
        ST_IDLE,
        ST_FRAME
    } t_state;

    t_state                  r_state, n_state;
    logic [ROW_W:0]          r_row, n_row;
    logic signed [OFS_W-1:0] r_ofs, n_ofs;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_fin, n_fin;
    logic                    r_scroll, n_scroll;

    logic [PIX_W-1:0]        r_mem [GLYPH_SLOTS * GLYPH_SIZE];
    logic [PIX_W-1:0]        r_rd0, r_rd1;

    // Read stage registers.
    logic                    r_s1_valid;
    logic [ROW_W-1:0]        r_s1_row;
    logic                    r_s1_last;
    logic                    r_s1_scroll;
    logic                    r_s1_v0, r_s1_v1;
    logic [GLYPH_LOG-1:0]    r_s1_shift;

    logic                    w_issue;
    logic                    w_blank;
    logic                    w_last;
    logic                    w_wr;
    logic signed [OFS_W:0]   w_g0;
    logic signed [OFS_W:0]   w_s0, w_s1;
    logic [OFS_W:0]          w_cnt_ext;
    logic                    w_v0, w_v1;
    logic [ADDR_W-1:0]       w_addr0, w_addr1, w_waddr;
    logic [2*PIX_W-1:0]      w_win;
    logic [2*PIX_W-1:0]      w_shifted;

    assign w_issue = (r_state == ST_FRAME);
    assign w_blank = r_row[ROW_W];
    assign w_last  = r_fin ? (r_row == '1) : (r_row[ROW_W-1:0] == '1);
    assign w_wr    = o_pop && i_head.is_load;

    // Strip column seen at display column zero, and the two glyphs that
    // the sixteen display columns can span.
    assign w_g0      = -{r_ofs[OFS_W-1], r_ofs};
    assign w_s0      = w_g0 >>> GLYPH_LOG;
    assign w_s1      = w_s0 + (OFS_W + 1)'(1);
    assign w_cnt_ext = (OFS_W + 1)'(r_count);
    assign w_v0      = !w_s0[OFS_W] && (w_s0 < $signed(w_cnt_ext)) &&
                       (w_s0 < (OFS_W + 1)'(GLYPH_SLOTS)) && !w_blank;
    assign w_v1      = !w_s1[OFS_W] && (w_s1 < $signed(w_cnt_ext)) &&
                       (w_s1 < (OFS_W + 1)'(GLYPH_SLOTS)) && !w_blank;
    assign w_addr0   = {w_s0[SLOT_W-1:0], r_row[ROW_W-1:0]};
    assign w_addr1   = {w_s1[SLOT_W-1:0], r_row[ROW_W-1:0]};
    assign w_waddr   = {i_head.slot, i_head.row};

    assign w_win     = {(r_s1_v0 ? r_rd0 : {PIX_W{1'b0}}),
                        (r_s1_v1 ? r_rd1 : {PIX_W{1'b0}})};
    assign w_shifted = w_win << r_s1_shift;

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_ofs    = r_ofs;
        n_count  = r_count;
        n_fin    = r_fin;
        n_scroll = r_scroll;
        o_pop    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_qstat.empty) begin
                    o_pop = 1'b1;
                    if (!i_head.is_load) begin
                        n_state  = ST_FRAME;
                        n_row    = '0;
                        n_ofs    = i_head.ofs;
                        n_count  = i_head.count;
                        n_fin    = i_head.fin;
                        n_scroll = i_head.scroll;
                    end
                end
            end
            ST_FRAME: begin
                n_row = r_row + 1'b1;
                if (w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_s1_valid   <= 1'b0;
            o_strobe     <= 1'b0;
            o_frame_row  <= '0;
            o_frame_bits <= '0;
            o_last       <= 1'b0;
            o_scrolling  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_s1_valid   <= w_issue;
            o_strobe     <= r_s1_valid;
            o_frame_row  <= r_s1_row;
            o_frame_bits <= w_shifted[2*PIX_W-1:PIX_W];
            o_last       <= r_s1_last;
            o_scrolling  <= r_s1_scroll;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row        <= n_row;
        r_ofs        <= n_ofs;
        r_count      <= n_count;
        r_fin        <= n_fin;
        r_scroll     <= n_scroll;
        r_s1_row     <= r_row[ROW_W-1:0];
        r_s1_last    <= w_issue && w_last;
        r_s1_scroll  <= r_scroll;
        r_s1_v0      <= w_v0;
        r_s1_v1      <= w_v1;
        r_s1_shift   <= w_g0[GLYPH_LOG-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_waddr] <= i_head.bits;
        end
        r_rd0 <= r_mem[w_addr0];
        r_rd1 <= r_mem[w_addr1];
    end

endmodule

// File: rtl/glyph_marquee_scroller.sv
// Top level of the glyph marquee scroller: front end, job queue, back end.
// Depends on gms_pkg, gms_front, gms_queue and gms_back.
//
// A beat is taken when start is high and busy is low; busy is high only
// while the four-entry job queue is full. Loads, starts and ticks each take
// one beat of the port. A tick that completes a scroll period queues a frame
// step; the back end renders it as 16 result beats (32 on the final step,
// the second frame blank), one per cycle, since both glyphs that a display
// row can span are read from the two read ports of the glyph store in the
// same cycle. Each row passes the glyph store read and read stage registers,
// then the output registers; the back end takes no new job until the last
// row of a step is issued, and writes a load to the store as it is taken.
// Results are strobed for exactly one cycle and cannot be held off by the receiver.
module glyph_marquee_scroller (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  i_cmd,
    input  logic [gms_pkg::SLOT_W-1:0]  i_glyph_index,
    input  logic [gms_pkg::ROW_W-1:0]   i_row_index,
    input  logic [gms_pkg::PIX_W-1:0]   i_row_bits,
    input  logic [gms_pkg::GCNT_W-1:0]  i_glyph_count,
    input  logic                        i_cfg_we,
    input  logic [gms_pkg::TICK_W-1:0]  i_cfg_wdata,
    output logic                        o_strobe,
    output logic [gms_pkg::ROW_W-1:0]   o_frame_row,
    output logic [gms_pkg::PIX_W-1:0]   o_frame_bits,
    output logic                        o_last,
    output logic                        o_scrolling
);
    import gms_pkg::*;

    logic   w_accept;
    logic   w_push;
    logic   w_pop;
    t_job   w_job;
    t_job   w_head;
    t_qstat w_qstat;

    assign busy     = w_qstat.full;
    assign w_accept = start && !busy;

    gms_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_cmd         (i_cmd),
        .i_glyph_index (i_glyph_index),
        .i_row_index   (i_row_index),
        .i_row_bits    (i_row_bits),
        .i_glyph_count (i_glyph_count),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_push        (w_push),
        .o_job         (w_job)
    );

    gms_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    gms_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_qstat      (w_qstat),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_frame_row  (o_frame_row),
        .o_frame_bits (o_frame_bits),
        .o_last       (o_last),
        .o_scrolling  (o_scrolling)
    );

endmodule

// File: rtl/gms_checker.sv
// Port-level checker for the glyph marquee scroller, bound to the top level.
// Depends on gms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gms_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_strobe,
    input logic [gms_pkg::ROW_W-1:0]   o_frame_row,
    input logic [gms_pkg::PIX_W-1:0]   o_frame_bits,
    input logic                        o_last,
    input logic                        o_scrolling
);
    import gms_pkg::*;

    // The end marker only ever rides on a strobed beat.
    `GMS_ASSERT_SAME(a_last_on_beat, o_last, o_strobe, "last without a result beat")

    // Rows of one step come back to back and in display order.
    `GMS_ASSERT_NEXT(a_rows_in_order, o_strobe && !o_last, o_strobe && (o_frame_row == ROW_W'($past(o_frame_row) + 1'b1)), "frame rows out of order or broken burst")

    // The scrolling flag is the same for every beat of one step.
    `GMS_ASSERT_NEXT(a_scroll_steady, o_strobe && !o_last, $stable(o_scrolling), "scrolling flag changed inside a step")

    // The final beat of a scroll belongs to the blank frame.
    `GMS_ASSERT_SAME(a_end_blank, o_strobe && o_last && !o_scrolling, o_frame_bits == '0, "closing frame not blank")

endmodule

bind glyph_marquee_scroller gms_checker u_gms_checker (.*);
